@@ rtl/midi_track_event_parser_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the track event parser checker.
// ---------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MTEP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/mtep_pkg.sv @@
// ---------------------------------------------------------------------------
// mtep_pkg
// Constants shared by the track event parser and its checker.
// ---------------------------------------------------------------------------
package mtep_pkg;
   localparam int NOTE_SLOTS_DEF = 16;
   localparam logic [15:0] TPS_RESET = 16'd120;
   localparam logic [2:0] KIND_NOTE = 3'd0;
   localparam logic [2:0] KIND_TEMPO = 3'd1;
   localparam logic [2:0] KIND_TIMESIG = 3'd2;
   localparam logic [2:0] KIND_PROGRAM = 3'd3;
   localparam logic [2:0] KIND_DROP = 3'd4;
   localparam logic [25:0] TEMPO_NUM = 26'd60000000;
   localparam logic [8:0] BPM_MAX = 9'd300;
   localparam logic [8:0] BPM_MIN = 9'd30;
   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] META_TIMESIG = 8'h58;
endpackage

@@ rtl/mtep_ram.sv @@
// ---------------------------------------------------------------------------
// mtep_ram
// Generic RAM with one write port, one read port and a registered read.
// ---------------------------------------------------------------------------
module mtep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/midi_track_event_parser_top.sv @@
// Timing: a result is registered after its byte is parsed; a tempo goes through 32
// divider steps and a saturation state, and a note-off that matches entry k searches the
// table up to that entry, divides for the start and end steps and moves each later entry up.
// Flow: no new byte is taken while a byte is still being processed (a running status data
// byte is parsed twice) or while a result waits on the output.
// Reset is synchronous and active high; the note table is not cleared.
// ---------------------------------------------------------------------------
// midi_track_event_parser_top
// Track chunk byte parser with a note table and one shared divider.
// ---------------------------------------------------------------------------
module midi_track_event_parser_top #(
   parameter int NOTE_SLOTS = mtep_pkg::NOTE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_track,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic        rsp_channel,
   output logic [15:0] rsp_start_step,
   output logic [15:0] rsp_duration,
   output logic [7:0]  rsp_pitch,
   output logic [7:0]  rsp_velocity,
   output logic [8:0]  rsp_value,
   output logic [7:0]  rsp_denominator_exponent,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_ticks_per_step
);
   localparam int AW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam int CW = $clog2(NOTE_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS = CW'(NOTE_SLOTS);

   localparam logic [3:0] PH_DELTA = 4'd0, PH_EVENT = 4'd1, PH_MTYPE = 4'd2,
      PH_MLEN = 4'd3, PH_TEMPO = 4'd4, PH_TSNUM = 4'd5, PH_TSDEN = 4'd6,
      PH_SXLEN = 4'd7, PH_SKIP = 4'd8, PH_DATA1 = 4'd9, PH_DATA2 = 4'd10;

   localparam logic [3:0] S_IDLE = 4'd0, S_PARSE = 4'd1, S_DIV = 4'd2,
      S_BPM = 4'd3, S_SRD = 4'd4, S_SCMP = 4'd5, S_SHRD = 4'd6, S_SHWR = 4'd7,
      S_DIVS = 4'd8, S_DIVE = 4'd9, S_NOTE = 4'd10, S_OUT = 4'd11;

   logic [3:0] st_ff, st_in;
   logic [3:0] ph_ff, ph_in;
   logic [31:0] tick_ff, tick_in, acc_ff, acc_in, skip_ff, skip_in;
   logic [7:0] rs_ff, rs_in, mt_ff, mt_in, hs_ff, hs_in, b_ff, b_in;
   logic [23:0] hb_ff, hb_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0] tps_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic [2:0] kind_ff, kind_in;
   logic ch_ff, ch_in;
   logic [15:0] ss_ff, ss_in, dur_ff, dur_in;
   logic [7:0] pit_ff, pit_in, vel_ff, vel_in, den_ff, den_in;
   logic [8:0] val_ff, val_in;
   logic vld_ff, vld_in;
   // shared shift-subtract divider
   logic [31:0] dq_ff, dq_in;
   logic [32:0] dr_ff, dr_in;
   logic [31:0] dd_ff, dd_in;
   logic [5:0] dc_ff, dc_in;
   logic [48:0] found_ff, found_in;
   logic [15:0] sstep_ff, sstep_in;
   // RAM
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [48:0] wr_data, rd_data;

   mtep_ram #(.WIDTH(49), .DEPTH(NOTE_SLOTS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign req_stall = (st_ff != S_IDLE) || vld_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_channel = ch_ff;
   assign rsp_start_step = ss_ff;
   assign rsp_duration = dur_ff;
   assign rsp_pitch = pit_ff;
   assign rsp_velocity = vel_ff;
   assign rsp_value = val_ff;
   assign rsp_denominator_exponent = den_ff;

   logic [31:0] vacc;
   logic [32:0] dtrial;
   logic [31:0] dsr;
   logic [15:0] tpsn;
   logic [32:0] rnd;
   logic [32:0] srnd;
   logic [CW:0] idx_p1, idx_p2;
   always_comb begin
      tpsn = (tps_ff == 16'd0) ? 16'd1 : tps_ff;
      rnd = {1'b0, tick_ff} + {18'd0, tpsn[15:1]};
      srnd = {1'b0, rd_data[39:8]} + {18'd0, tpsn[15:1]};
      idx_p1 = (CW+1)'(idx_ff) + (CW+1)'(1);
      idx_p2 = (CW+1)'(idx_ff) + (CW+1)'(2);
      st_in = st_ff; ph_in = ph_ff; tick_in = tick_ff; acc_in = acc_ff;
      skip_in = skip_ff; rs_in = rs_ff; mt_in = mt_ff; hs_in = hs_ff;
      b_in = b_ff; hb_in = hb_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      kind_in = kind_ff; ch_in = ch_ff; ss_in = ss_ff; dur_in = dur_ff;
      pit_in = pit_ff; vel_in = vel_ff; den_in = den_ff; val_in = val_ff;
      vld_in = vld_ff && rsp_stall;
      dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff; dc_in = dc_ff;
      found_in = found_ff; sstep_in = sstep_ff;
      wr_en = 1'b0; wr_addr = idx_ff; wr_data = rd_data; rd_addr = idx_ff;
      vacc = {acc_ff[24:0], b_ff[6:0]};
      dtrial = {dr_ff[31:0], dq_ff[31]} - {1'b0, dd_ff};
      dsr = 32'd0;
      case (st_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               b_in = req_data_byte;
               st_in = S_PARSE;
               kind_in = mtep_pkg::KIND_NOTE; ch_in = 1'b0; ss_in = 16'd0;
               dur_in = 16'd0; pit_in = 8'd0; vel_in = 8'd0; val_in = 9'd0;
               den_in = 8'd0;
               if (req_first_of_track) begin
                  tick_in = 32'd0; rs_in = 8'd0; ph_in = PH_DELTA;
                  acc_in = 32'd0; skip_in = 32'd0; hb_in = 24'd0;
               end
            end
         end
         S_PARSE: begin
            st_in = S_IDLE;
            case (ph_ff)
               PH_EVENT: begin
                  if (b_ff == 8'hFF) begin
                     ph_in = PH_MTYPE;
                  end else if (b_ff >= 8'hF0) begin
                     if (b_ff == 8'hF0 || b_ff == 8'hF7) begin
                        acc_in = 32'd0; ph_in = PH_SXLEN;
                     end else begin
                        ph_in = PH_DELTA;
                     end
                  end else if (b_ff[7]) begin
                     rs_in = b_ff; hs_in = b_ff;
                     if (b_ff[7:4] == 4'hA || b_ff[7:4] == 4'hB || b_ff[7:4] == 4'hE)
                     begin
                        skip_in = 32'd2; ph_in = PH_SKIP;
                     end else begin
                        ph_in = PH_DATA1;
                     end
                  end else if (rs_ff[7]) begin
                     hs_in = rs_ff;
                     ph_in = PH_DATA1;
                     st_in = S_PARSE;
                  end else begin
                     tick_in = tick_ff + {24'd0, b_ff};
                  end
               end
               PH_MTYPE: begin
                  mt_in = b_ff; acc_in = 32'd0; ph_in = PH_MLEN;
               end
               PH_MLEN: begin
                  acc_in = vacc;
                  if (!b_ff[7]) begin
                     acc_in = 32'd0; hb_in = 24'd0;
                     if (mt_ff == mtep_pkg::META_TEMPO && vacc == 32'd3) begin
                        skip_in = 32'd3; ph_in = PH_TEMPO;
                     end else if (mt_ff == mtep_pkg::META_TIMESIG && vacc >= 32'd2) begin
                        skip_in = vacc; ph_in = PH_TSNUM;
                     end else begin
                        skip_in = vacc;
                        ph_in = (vacc != 32'd0) ? PH_SKIP : PH_DELTA;
                     end
                  end
               end
               PH_TEMPO: begin
                  hb_in = {hb_ff[15:0], b_ff};
                  skip_in = skip_ff - 32'd1;
                  if (skip_ff == 32'd1) begin
                     ph_in = PH_DELTA;
                     dq_in = {6'd0, mtep_pkg::TEMPO_NUM};
                     dd_in = {8'd0, hb_ff[15:0], b_ff};
                     dr_in = 33'd0; dc_in = 6'd32;
                     st_in = S_DIV;
                  end
               end
               PH_TSNUM: begin
                  hb_in = {16'd0, b_ff}; ph_in = PH_TSDEN;
               end
               PH_TSDEN: begin
                  kind_in = mtep_pkg::KIND_TIMESIG; val_in = {1'b0, hb_ff[7:0]};
                  den_in = b_ff; vld_in = 1'b1;
                  skip_in = skip_ff - 32'd2;
                  ph_in = (skip_ff != 32'd2) ? PH_SKIP : PH_DELTA;
               end
               PH_SXLEN: begin
                  acc_in = vacc;
                  if (!b_ff[7]) begin
                     acc_in = 32'd0; skip_in = vacc;
                     ph_in = (vacc != 32'd0) ? PH_SKIP : PH_DELTA;
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_ff - 32'd1;
                  if (skip_ff == 32'd1) ph_in = PH_DELTA;
               end
               PH_DATA1: begin
                  if (hs_ff[7:4] == 4'h8 || hs_ff[7:4] == 4'h9) begin
                     hb_in = {16'd0, b_ff}; ph_in = PH_DATA2;
                  end else if (hs_ff[7:4] == 4'hC || hs_ff[7:4] == 4'hD) begin
                     ph_in = PH_DELTA;
                     if (hs_ff[7:4] == 4'hC && hs_ff[3:1] == 3'd0) begin
                        kind_in = mtep_pkg::KIND_PROGRAM; ch_in = hs_ff[0];
                        val_in = {1'b0, b_ff}; vld_in = 1'b1;
                     end
                  end else begin
                     skip_in = 32'd1; ph_in = PH_SKIP;
                  end
               end
               PH_DATA2: begin
                  ph_in = PH_DELTA;
                  if (hs_ff[7:4] == 4'h9 && b_ff != 8'd0) begin
                     if (hs_ff[3:1] == 3'd0) begin
                        if (cnt_ff < SLOTS) begin
                           wr_en = 1'b1; wr_addr = cnt_ff[AW-1:0];
                           wr_data = {hb_ff[7:0], hs_ff[0], tick_ff, b_ff};
                           cnt_in = cnt_ff + CW'(1);
                        end else begin
                           kind_in = mtep_pkg::KIND_DROP; ch_in = hs_ff[0];
                           pit_in = hb_ff[7:0]; vel_in = b_ff; vld_in = 1'b1;
                        end
                     end
                  end else if (cnt_ff != '0) begin
                     idx_in = '0; st_in = S_SRD;
                  end
               end
               default: begin
                  acc_in = vacc;
                  if (!b_ff[7]) begin
                     tick_in = tick_ff + vacc; acc_in = 32'd0; ph_in = PH_EVENT;
                  end else begin
                     ph_in = PH_DELTA;
                  end
               end
            endcase
         end
         S_DIV, S_DIVS, S_DIVE: begin
            dq_in = {dq_ff[30:0], !dtrial[32]};
            dr_in = dtrial[32] ? {dr_ff[31:0], dq_ff[31]} : dtrial;
            dc_in = dc_ff - 6'd1;
            if (dc_ff == 6'd1) begin
               dsr = {dq_ff[30:0], !dtrial[32]};
               if (st_ff == S_DIV) begin
                  st_in = S_BPM;
                  dq_in = dsr;
               end else if (st_ff == S_DIVS) begin
                  sstep_in = dsr[15:0];
                  dq_in = rnd[31:0]; dd_in = {16'd0, tpsn};
                  dr_in = (tpsn == 16'd1) ? 33'd0 : {32'd0, rnd[32]};
                  dc_in = 6'd32; st_in = S_DIVE;
               end else begin
                  ss_in = sstep_ff;
                  dur_in = (dsr[15:0] > sstep_ff) ? dsr[15:0] - sstep_ff : 16'd1;
                  st_in = S_NOTE;
               end
            end
         end
         S_BPM: begin
            kind_in = mtep_pkg::KIND_TEMPO;
            if (dd_ff == 32'd0 || dq_ff > 32'(mtep_pkg::BPM_MAX))
               val_in = mtep_pkg::BPM_MAX;
            else if (dq_ff < 32'(mtep_pkg::BPM_MIN)) val_in = mtep_pkg::BPM_MIN;
            else val_in = dq_ff[8:0];
            vld_in = 1'b1; st_in = S_IDLE;
         end
         S_SRD: begin
            st_in = S_SCMP;
         end
         S_SCMP: begin
            if (rd_data[48:41] == hb_ff[7:0] && rd_data[40] == hs_ff[0]
                && hs_ff[3:1] == 3'd0) begin
               found_in = rd_data;
               dq_in = srnd[31:0];
               dr_in = (tpsn == 16'd1) ? 33'd0 : {32'd0, srnd[32]};
               dc_in = 6'd32; dd_in = {16'd0, tpsn};
               st_in = S_DIVS;
            end else if (idx_p1 >= {1'b0, cnt_ff}) begin
               st_in = S_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1); st_in = S_SRD;
            end
         end
         S_NOTE: begin
            kind_in = mtep_pkg::KIND_NOTE; ch_in = found_ff[40];
            pit_in = found_ff[48:41]; vel_in = found_ff[7:0];
            st_in = S_SHRD; rd_addr = idx_ff + AW'(1);
            if (idx_p1 >= {1'b0, cnt_ff}) begin
               cnt_in = cnt_ff - CW'(1); vld_in = 1'b1; st_in = S_OUT;
            end
         end
         S_SHRD: begin
            rd_addr = idx_ff + AW'(1); st_in = S_SHWR;
         end
         S_SHWR: begin
            wr_en = 1'b1; wr_addr = idx_ff; wr_data = rd_data;
            idx_in = idx_ff + AW'(1);
            rd_addr = idx_ff + AW'(1);
            if (idx_p2 >= {1'b0, cnt_ff}) begin
               cnt_in = cnt_ff - CW'(1); vld_in = 1'b1; st_in = S_OUT;
            end else begin
               st_in = S_SHRD;
            end
         end
         S_OUT: begin
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // The tick-plus-half sum is 33 bits; its low 32 bits are the dividend and its
   // top bit is preloaded into the remainder whenever it is below the divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ph_ff <= PH_DELTA; tick_ff <= 32'd0; acc_ff <= 32'd0;
         skip_ff <= 32'd0; rs_ff <= 8'd0; mt_ff <= 8'd0; hs_ff <= 8'd0;
         hb_ff <= 24'd0; cnt_ff <= '0; vld_ff <= 1'b0;
         tps_ff <= mtep_pkg::TPS_RESET;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; tick_ff <= tick_in; acc_ff <= acc_in;
         skip_ff <= skip_in; rs_ff <= rs_in; mt_ff <= mt_in; hs_ff <= hs_in;
         hb_ff <= hb_in; cnt_ff <= cnt_in; vld_ff <= vld_in;
         if (csr_valid && csr_ready) tps_ff <= csr_ticks_per_step;
      end
      b_ff <= b_in; idx_ff <= idx_in; kind_ff <= kind_in; ch_ff <= ch_in;
      ss_ff <= ss_in; dur_ff <= dur_in; pit_ff <= pit_in; vel_ff <= vel_in;
      den_ff <= den_in; val_ff <= val_in; dq_ff <= dq_in; dr_ff <= dr_in;
      dd_ff <= dd_in; dc_ff <= dc_in; found_ff <= found_in; sstep_ff <= sstep_in;
   end
endmodule

@@ rtl/mtep_checker.sv @@
// ---------------------------------------------------------------------------
// mtep_checker
// Port-level checks of the track event parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "midi_track_event_parser_top_macros.svh"
module mtep_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_result_kind,
   input logic [8:0] rsp_value
);
   `MTEP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")
   `MTEP_ASSERT_IMP(a_kind_range, clock, reset, rsp_valid, rsp_result_kind <= mtep_pkg::KIND_DROP, "result kind out of range")
   `MTEP_ASSERT_IMP(a_bpm_range, clock, reset, rsp_valid && rsp_result_kind == mtep_pkg::KIND_TEMPO, rsp_value >= mtep_pkg::BPM_MIN && rsp_value <= mtep_pkg::BPM_MAX, "tempo outside its range")
   `MTEP_ASSERT_IMP(a_busy_out, clock, reset, rsp_valid, req_stall, "word taken while a result waits")
endmodule

bind midi_track_event_parser_top mtep_checker u_mtep_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_result_kind(rsp_result_kind), .rsp_value(rsp_value));

@@ tb/midi_track_event_parser_checker.sv @@
// ---------------------------------------------------------------------------
// midi_track_event_parser_checker
// Watches the byte, event and register channels of the track event parser.
// It predicts every event word from the accepted bytes and checks each
// returned word against the oldest prediction.
// ---------------------------------------------------------------------------
module midi_track_event_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_track,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_result_kind,
   input  logic        rsp_channel,
   input  logic [15:0] rsp_start_step,
   input  logic [15:0] rsp_duration,
   input  logic [7:0]  rsp_pitch,
   input  logic [7:0]  rsp_velocity,
   input  logic [8:0]  rsp_value,
   input  logic [7:0]  rsp_denominator_exponent,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_ticks_per_step,
   output int          fail_count,
   output int          pending
);
   localparam int SLOTS = mtep_pkg::NOTE_SLOTS_DEF;
   localparam logic [7:0] META_PREFIX = 8'hFF;
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END = 8'hF7;
   localparam logic [3:0] ST_NOTE_OFF = 4'h8;
   localparam logic [3:0] ST_NOTE_ON = 4'h9;
   localparam logic [3:0] ST_POLY = 4'hA;
   localparam logic [3:0] ST_CONTROL = 4'hB;
   localparam logic [3:0] ST_PROGRAM = 4'hC;
   localparam logic [3:0] ST_PRESSURE = 4'hD;
   localparam logic [3:0] ST_BEND = 4'hE;

   typedef enum logic [3:0] {
      PH_DELTA, PH_EVENT, PH_META_TYPE, PH_META_LEN, PH_TEMPO, PH_TS_NUM,
      PH_TS_DEN, PH_SYSEX_LEN, PH_SKIP, PH_DATA1, PH_DATA2
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        chan;
      logic [15:0] start;
      logic [15:0] dur;
      logic [7:0]  pitch;
      logic [7:0]  vel;
      logic [8:0]  value;
      logic [7:0]  den;
   } event_word_type;

   event_word_type expected_events[$];
   event_word_type word;
   logic        word_out;

   logic [15:0] tps;
   logic [31:0] tick;
   logic [7:0]  rstat;
   phase_type   phase;
   logic [31:0] acc;
   logic [31:0] skip;
   logic [7:0]  meta;
   logic [23:0] held;
   logic [7:0]  hstat;
   logic [7:0]  slot_pitch [SLOTS];
   logic [3:0]  slot_chan [SLOTS];
   logic [31:0] slot_tick [SLOTS];
   logic [7:0]  slot_vel [SLOTS];
   int          note_count;

   function automatic logic [15:0] tick_to_step(input logic [31:0] t);
      logic [63:0] d;
      logic [63:0] q;
      d = (tps == 16'd0) ? 64'd1 : {48'd0, tps};
      q = ({32'd0, t} + d / 2) / d;
      return q[15:0];
   endfunction

   task automatic skip_bytes(input logic [31:0] n);
      skip = n;
      phase = (n != 0) ? PH_SKIP : PH_DELTA;
   endtask

   task automatic first_data(input logic [7:0] b);
      if (hstat[7:4] == ST_NOTE_OFF || hstat[7:4] == ST_NOTE_ON) begin
         held = {16'd0, b};
         phase = PH_DATA2;
      end else if (hstat[7:4] == ST_PROGRAM || hstat[7:4] == ST_PRESSURE) begin
         phase = PH_DELTA;
         if (hstat[7:4] == ST_PROGRAM && hstat[3:0] <= 4'd1) begin
            word.kind = mtep_pkg::KIND_PROGRAM;
            word.chan = hstat[0];
            word.value = {1'b0, b};
            word_out = 1'b1;
         end
      end else begin
         skip_bytes(1);
      end
   endtask

   task automatic note_data(input logic [7:0] v);
      logic [15:0] s;
      logic [15:0] e;
      logic        found;
      found = 1'b0;
      phase = PH_DELTA;
      if (hstat[7:4] == ST_NOTE_ON && v != 8'd0) begin
         if (hstat[3:0] <= 4'd1) begin
            if (note_count < SLOTS) begin
               slot_pitch[note_count] = held[7:0];
               slot_chan[note_count] = hstat[3:0];
               slot_tick[note_count] = tick;
               slot_vel[note_count] = v;
               note_count++;
            end else begin
               word.kind = mtep_pkg::KIND_DROP;
               word.chan = hstat[0];
               word.pitch = held[7:0];
               word.vel = v;
               word_out = 1'b1;
            end
         end
      end else begin
         for (int i = 0; i < note_count; i++) begin
            if (!found && slot_pitch[i] == held[7:0] && slot_chan[i] == hstat[3:0]) begin
               found = 1'b1;
               s = tick_to_step(slot_tick[i]);
               e = tick_to_step(tick);
               word.kind = mtep_pkg::KIND_NOTE;
               word.chan = hstat[0];
               word.start = s;
               word.dur = (e > s) ? e - s : 16'd1;
               word.pitch = slot_pitch[i];
               word.vel = slot_vel[i];
               word_out = 1'b1;
               for (int j = i; j < note_count - 1; j++) begin
                  slot_pitch[j] = slot_pitch[j + 1];
                  slot_chan[j] = slot_chan[j + 1];
                  slot_tick[j] = slot_tick[j + 1];
                  slot_vel[j] = slot_vel[j + 1];
               end
            end
         end
         if (found) note_count--;
      end
   endtask

   task automatic take_byte(input logic [7:0] b, input logic first);
      logic [31:0] len;
      logic [31:0] bpm;
      word = '0;
      word_out = 1'b0;
      if (first) begin
         tick = '0;
         rstat = '0;
         phase = PH_DELTA;
         acc = '0;
         skip = '0;
         held = '0;
      end
      case (phase)
         PH_EVENT: begin
            if (b == META_PREFIX) begin
               phase = PH_META_TYPE;
            end else if (b >= SYSEX_START) begin
               if (b == SYSEX_START || b == SYSEX_END) begin
                  acc = '0;
                  phase = PH_SYSEX_LEN;
               end else begin
                  phase = PH_DELTA;
               end
            end else if (b[7]) begin
               rstat = b;
               hstat = b;
               if (b[7:4] == ST_POLY || b[7:4] == ST_CONTROL || b[7:4] == ST_BEND)
                  skip_bytes(2);
               else
                  phase = PH_DATA1;
            end else if (rstat[7]) begin
               hstat = rstat;
               first_data(b);
            end else begin
               tick += {24'd0, b};
            end
         end
         PH_META_TYPE: begin
            meta = b;
            acc = '0;
            phase = PH_META_LEN;
         end
         PH_META_LEN: begin
            acc = {acc[24:0], b[6:0]};
            if (!b[7]) begin
               len = acc;
               acc = '0;
               held = '0;
               if (meta == mtep_pkg::META_TEMPO && len == 32'd3) begin
                  skip = 3;
                  phase = PH_TEMPO;
               end else if (meta == mtep_pkg::META_TIMESIG && len >= 32'd2) begin
                  skip = len;
                  phase = PH_TS_NUM;
               end else begin
                  skip_bytes(len);
               end
            end
         end
         PH_TEMPO: begin
            held = {held[15:0], b};
            skip--;
            if (skip == 0) begin
               bpm = (held == 24'd0) ? 32'd300 : mtep_pkg::TEMPO_NUM / {8'd0, held};
               if (bpm > mtep_pkg::BPM_MAX) bpm = mtep_pkg::BPM_MAX;
               if (bpm < mtep_pkg::BPM_MIN) bpm = mtep_pkg::BPM_MIN;
               word.kind = mtep_pkg::KIND_TEMPO;
               word.value = bpm[8:0];
               word_out = 1'b1;
               phase = PH_DELTA;
            end
         end
         PH_TS_NUM: begin
            held = {16'd0, b};
            phase = PH_TS_DEN;
         end
         PH_TS_DEN: begin
            word.kind = mtep_pkg::KIND_TIMESIG;
            word.value = {1'b0, held[7:0]};
            word.den = b;
            word_out = 1'b1;
            skip_bytes(skip - 2);
         end
         PH_SYSEX_LEN: begin
            acc = {acc[24:0], b[6:0]};
            if (!b[7]) begin
               len = acc;
               acc = '0;
               skip_bytes(len);
            end
         end
         PH_SKIP: begin
            skip--;
            if (skip == 0) phase = PH_DELTA;
         end
         PH_DATA1: first_data(b);
         PH_DATA2: note_data(b);
         default: begin
            acc = {acc[24:0], b[6:0]};
            if (!b[7]) begin
               tick += acc;
               acc = '0;
               phase = PH_EVENT;
            end else begin
               phase = PH_DELTA;
            end
         end
      endcase
      if (word_out) expected_events = {expected_events, word};
   endtask

   always @(posedge clock) begin
      event_word_type got;
      event_word_type want;
      if (reset) begin
         tps = mtep_pkg::TPS_RESET;
         tick = '0;
         rstat = '0;
         phase = PH_DELTA;
         acc = '0;
         skip = '0;
         meta = '0;
         held = '0;
         hstat = '0;
         note_count = 0;
         expected_events.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_result_kind, rsp_channel, rsp_start_step, rsp_duration, rsp_pitch,
                    rsp_velocity, rsp_value, rsp_denominator_exponent};
            if (expected_events.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected event word, expected none, actual %p", $time, got);
            end else begin
               want = expected_events.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: event word mismatch, expected %p, actual %p",
                           $time, want, got);
               end
            end
         end
         if (csr_valid && csr_ready) tps = csr_ticks_per_step;
         if (req_valid && !req_stall) take_byte(req_data_byte, req_first_of_track);
      end
      pending = expected_events.size();
   end
endmodule

@@ tb/tb_midi_track_event_parser_top.sv @@
// ---------------------------------------------------------------------------
// tb_midi_track_event_parser_top
// Drives track bytes and ticks per step settings into the track event parser,
// with random gaps and back-pressure, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_midi_track_event_parser_top;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 300;
   localparam logic [3:0] ST_NOTE_ON_NIB = 4'h9;
   localparam logic [3:0] ST_NOTE_OFF_NIB = 4'h8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_first_of_track;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_result_kind;
   logic        rsp_channel;
   logic [15:0] rsp_start_step;
   logic [15:0] rsp_duration;
   logic [7:0]  rsp_pitch;
   logic [7:0]  rsp_velocity;
   logic [8:0]  rsp_value;
   logic [7:0]  rsp_denominator_exponent;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_ticks_per_step;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   bit          quiet;
   bit          hold_long;
   bit          note_heavy;
   logic [7:0]  last_status;

   midi_track_event_parser_top u_dut (.*);

   midi_track_event_parser_checker u_checker (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_long = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic first = 1'b0);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_first_of_track <= first;
      do @(posedge clock); while (req_stall);
      if (first) last_status = 8'h00;
   endtask

   task automatic send_varlen(input int unsigned v, input logic first);
      int n;
      n = 1;
      while (n < 5 && (v >> (7 * n)) != 0) n++;
      for (int k = n - 1; k >= 0; k--)
         send_byte(8'(((v >> (7 * k)) & 32'h7F) | ((k != 0) ? 32'h80 : 32'h0)),
                   first && (k == n - 1));
   endtask

   task automatic send_status(input logic [7:0] st);
      if (st != last_status || $urandom_range(0, 2) != 0) send_byte(st);
      last_status = st;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ticks_per_step(input logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_ticks_per_step <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_event();
      int          sel;
      int          len;
      logic [3:0]  ch;
      logic [7:0]  pitch;
      logic [23:0] tempo;
      sel = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(2, 15)) : 4'($urandom_range(0, 1));
      pitch = 8'($urandom_range(60, 67));
      if ($urandom_range(0, 39) == 0)
         repeat (6) send_byte(8'hFF, 1'b0);
      if ($urandom_range(0, 9) == 0)
         send_varlen($urandom_range(0, 30000), $urandom_range(0, 49) == 0);
      else
         send_varlen($urandom_range(0, 240), $urandom_range(0, 49) == 0);
      if (sel < (note_heavy ? 60 : 30)) begin
         send_status({ST_NOTE_ON_NIB, ch});
         send_byte(pitch);
         send_byte(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 127)));
      end else if (sel < 60) begin
         if ($urandom_range(0, 1) == 0) begin
            send_status({ST_NOTE_OFF_NIB, ch});
            send_byte(pitch);
            send_byte(8'($urandom_range(0, 127)));
         end else begin
            send_status({ST_NOTE_ON_NIB, ch});
            send_byte(pitch);
            send_byte(8'd0);
         end
      end else if (sel < 68) begin
         send_status({4'hC, ch});
         send_byte(8'($urandom_range(0, 127)));
      end else if (sel < 72) begin
         send_status({4'hD, ch});
         send_byte(8'($urandom_range(0, 127)));
      end else if (sel < 76) begin
         send_status({4'($urandom_range(0, 2) == 0 ? 4'hA : ($urandom_range(0, 1) ? 4'hB : 4'hE)), ch});
         send_byte(8'($urandom_range(0, 127)));
         send_byte(8'($urandom_range(0, 127)));
      end else if (sel < 81) begin
         send_byte(8'hFF);
         send_byte(mtep_pkg::META_TEMPO);
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 3;
         send_byte(8'(len));
         case ($urandom_range(0, 3))
            0: tempo = 24'($urandom_range(0, 300000));
            1: tempo = 24'($urandom_range(0, 3));
            default: tempo = 24'($urandom);
         endcase
         for (int k = 0; k < len; k++) send_byte(8'(tempo >> (8 * ((2 - k) & 3))));
      end else if (sel < 85) begin
         send_byte(8'hFF);
         send_byte(mtep_pkg::META_TIMESIG);
         len = $urandom_range(0, 5);
         send_byte(8'(len));
         for (int k = 0; k < len; k++) send_byte(8'($urandom));
      end else if (sel < 88) begin
         send_byte(8'hFF);
         send_byte(8'($urandom));
         len = $urandom_range(0, 3);
         send_byte(8'(len));
         for (int k = 0; k < len; k++) send_byte(8'($urandom));
      end else if (sel < 91) begin
         send_byte($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
         len = $urandom_range(0, 3);
         send_byte(8'(len));
         for (int k = 0; k < len; k++) send_byte(8'($urandom));
      end else if (sel < 94) begin
         send_byte(8'($urandom_range(8'hF1, 8'hFE)));
      end else begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end
   endtask

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) note_heavy = ($urandom_range(0, 2) == 0);
         random_event();
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_first_of_track = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_ticks_per_step = '0;
      quiet = 1'b0;
      hold_long = 1'b0;
      note_heavy = 1'b0;
      last_status = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A data byte with no running status is taken as a delta time.
      send_byte(8'h00, 1'b1);
      send_byte(8'h40);
      send_byte(8'hC0);
      send_byte(8'h07);
      send_byte(8'h00);
      send_byte(8'h90);
      send_byte(8'h3C);
      send_byte(8'h7F);
      // Running status note-on with zero velocity closes the note.
      send_byte(8'h81);
      send_byte(8'h00);
      send_byte(8'h3C);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(mtep_pkg::META_TEMPO);
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(mtep_pkg::META_TIMESIG);
      send_byte(8'h02);
      send_byte(8'h06);
      send_byte(8'h03);
      settle();

      write_ticks_per_step(16'd1);
      random_phase(30);
      hold_long = 1'b1;
      random_phase(30);
      settle();
      write_ticks_per_step(16'hFFFF);
      random_phase(55);
      settle();
      write_ticks_per_step(16'($urandom_range(2, 1000)));
      random_phase(55);
      settle();
      write_ticks_per_step(mtep_pkg::TPS_RESET);
      quiet = 1'b1;
      random_phase(25);

      settle();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
